// ----- sv/maw_pkg.sv -----
// Shared types and constants for the moving average window core.
`default_nettype none

package maw_pkg;

    localparam int CFG_W        = 7;
    localparam int WINDOW_RESET = 8;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- sv/maw_div.sv -----
// Restoring divider, one quotient bit per cycle, for unsigned magnitudes.
`default_nettype none

module maw_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [NUM_W-1:0]      i_num,
    input  wire logic [DEN_W-1:0]      i_den,
    output logic      [NUM_W-1:0]      o_quo,
    output maw_pkg::t_div_stat         o_stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = trial >= {1'b0, i_den};
        diff  = trial - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], ge};
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_num;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ----- sv/moving_average_window_core.sv -----
// Boxcar moving average over a configurable ring window of signed samples.
//
// Input stream (s_axis) takes one signed sample per request; output stream
// (m_axis) returns one average per sample, the window sum divided by the
// window size and truncated toward zero. Slots not written since the last
// clear count as zero.
// The cfg channel writes the window size (0 is taken as 1, values above
// MAX_WINDOW as MAX_WINDOW); a write clears the window and the write pointer.
// Write it only while no sample is in flight.
// Each sample steps through the SUM, LOAD, DIV and DONE states and the next
// is taken only once the block is back in IDLE; DIV waits on the bit-serial
// restoring divider that produces one quotient bit a cycle.
// A finished result waits in the output register; the next sample is
// accepted meanwhile, and a stalled receiver holds the block only once the
// following result is ready.
// Reset sets the window size to 8 and empties the window; the window store
// needs no clearing pass, a wrap flag marks when old slots become live.
`default_nettype none

module moving_average_window_core #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [SAMPLE_BITS-1:0] sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [SAMPLE_BITS-1:0] average
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]   o_m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [maw_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WS     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam logic [WS-1:0] WIN_RST = (maw_pkg::WINDOW_RESET > MAX_WINDOW) ?
                                        WS'(MAX_WINDOW) : WS'(maw_pkg::WINDOW_RESET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                         r_state;
    logic [WS-1:0]                  r_win;
    logic [AW-1:0]                  r_wpos;
    logic                           r_wrapped;
    logic signed [SUM_W-1:0]        r_sum;
    logic signed [SAMPLE_BITS-1:0]  r_sample;
    logic signed [SAMPLE_BITS-1:0]  r_rd_data;
    logic                           r_neg;
    logic                           r_m_valid;
    logic [DATA_W-1:0]              r_m_data;

    logic signed [SAMPLE_BITS-1:0]  r_mem [MAX_WINDOW];

    logic                           s_fire;
    logic                           cfg_fire;
    logic                           mem_wr;
    logic signed [SAMPLE_BITS-1:0]  old_val;
    logic signed [SUM_W-1:0]        n_sum;
    logic                           wpos_last;
    logic [SUM_W-1:0]               mag;
    logic [WS-1:0]                  win_clamped;
    logic                           div_start;
    logic [SUM_W-1:0]               quo;
    maw_pkg::t_div_stat             div_stat;
    logic [SAMPLE_BITS-1:0]         q_low;
    logic [SAMPLE_BITS-1:0]         avg;

    assign o_s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_fire        = i_cfg_valid && o_cfg_ready;
    assign mem_wr          = (r_state == ST_SUM);
    assign div_start       = (r_state == ST_LOAD);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_comb begin
        old_val   = r_wrapped ? r_rd_data : '0;
        n_sum     = r_sum - SUM_W'(old_val) + SUM_W'(r_sample);
        wpos_last = (WS'(r_wpos) + WS'(1)) >= r_win;
        mag       = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        q_low     = quo[SAMPLE_BITS-1:0];
        avg       = r_neg ? -q_low : q_low;
        if (i_cfg_data == '0) begin
            win_clamped = WS'(1);
        end else if (int'(i_cfg_data) > MAX_WINDOW) begin
            win_clamped = WS'(MAX_WINDOW);
        end else begin
            win_clamped = WS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wpos] <= r_sample;
        end
        if (s_fire) begin
            r_rd_data <= r_mem[r_wpos];
        end
    end

    maw_div #(
        .NUM_W (SUM_W),
        .DEN_W (WS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag),
        .i_den   (r_win),
        .o_quo   (quo),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_win     <= WIN_RST;
            r_wpos    <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && i_m_axis_tready && (r_state != ST_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        r_win     <= win_clamped;
                        r_wpos    <= '0;
                        r_wrapped <= 1'b0;
                        r_sum     <= '0;
                    end else if (s_fire) begin
                        r_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
                        r_state  <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_sum <= n_sum;
                    if (wpos_last) begin
                        r_wpos    <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_wpos <= r_wpos + AW'(1);
                    end
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_data  <= DATA_W'(avg);
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_wpos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WS'(r_wpos) < r_win)
        else $error("write pointer outside window");

    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win != '0 && int'(r_win) <= MAX_WINDOW)
        else $error("window size out of range");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> r_sum == '0 && r_wpos == '0 && !r_wrapped)
        else $error("window not cleared by cfg request");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> div_stat.busy || div_stat.done)
        else $error("divider idle while waiting on it");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == ST_DIV)
        else $error("divider result outside divide phase");
`endif

endmodule

`default_nettype wire

// ----- sim/moving_average_window_core_tb.sv -----
// Self-checking testbench for the boxcar moving average core: stream stimulus, scoreboard, stalls.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_WIN      = 64;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_W        = maw_pkg::CFG_W;
    localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SETTLE_WAIT  = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_COUNT  = 14;
    localparam int PHASE_ITEMS  = 90;
    localparam int STALL_ITEMS  = 60;

    typedef enum int {SRC_MIXED, SRC_LOW, SRC_HIGH} t_sample_src;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [DATA_W-1:0]    s_data = '0;
    logic                 m_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_W-1:0]     cfg_data = '0;
    wire                  s_ready;
    wire                  m_valid;
    wire  [DATA_W-1:0]    m_data;
    wire                  cfg_ready;

    logic signed [SAMPLE_W-1:0] avg_window [MAX_WIN];
    int                   avg_pos;
    int                   avg_sum;
    int                   avg_len;
    logic [SAMPLE_W-1:0]  expected_avg [$];

    int                   error_count = 0;
    int                   cycle_count = 0;
    bit                   no_idle = 1'b0;
    bit                   hold_req = 1'b0;

    moving_average_window_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("moving_average_window_core test failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void clear_window(input int len);
        for (int i = 0; i < MAX_WIN; i++) begin
            avg_window[i] = '0;
        end
        avg_pos = 0;
        avg_sum = 0;
        if (len < 1) begin
            avg_len = 1;
        end else if (len > MAX_WIN) begin
            avg_len = MAX_WIN;
        end else begin
            avg_len = len;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_average(input logic signed [SAMPLE_W-1:0] s);
        int avg;
        if (avg_pos >= avg_len) begin
            avg_pos = 0;
        end
        avg_sum = avg_sum - int'(avg_window[avg_pos]);
        avg_window[avg_pos] = s;
        avg_sum = avg_sum + int'(s);
        avg_pos++;
        if (avg_pos >= avg_len) begin
            avg_pos = 0;
        end
        avg = avg_sum / avg_len;
        return avg[SAMPLE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample(input t_sample_src src);
        logic [31:0] r;
        r = $urandom();
        case (src)
            SRC_LOW: begin
                return 16'h8000 + 16'($urandom_range(0, 255));
            end
            SRC_HIGH: begin
                return 16'h7fff - 16'($urandom_range(0, 255));
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    default: return r[SAMPLE_W-1:0];
                endcase
            end
        endcase
    endfunction

    // Enter and leave at a falling edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= DATA_W'(s);
        do @(posedge i_clk); while (!s_ready);
        expected_avg.push_back(next_average(s));
        @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] len);
        s_valid <= 1'b0;
        while (expected_avg.size() != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge i_clk); while (!cfg_ready);
        clear_window(int'(len));
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random hold-off per result, long hold on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_valid && m_ready));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_avg.size() == 0) begin
                report($sformatf("unexpected average %0d", $signed(m_data[SAMPLE_W-1:0])));
            end else begin
                if (m_data[SAMPLE_W-1:0] !== expected_avg[0]) begin
                    report($sformatf("average got %0d, want %0d",
                        $signed(m_data[SAMPLE_W-1:0]), $signed(expected_avg[0])));
                end
                void'(expected_avg.pop_front());
            end
        end
    end

    task automatic test_reset_window();
        repeat (8) send_sample(16'h7fff);
        repeat (3) send_sample(16'h8000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h0000);
        s_valid <= 1'b0;
    endtask

    task automatic test_window_clamp();
        write_window(7'd0);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'hfffd);
        write_window(7'd127);
        send_sample(16'hffff);
        send_sample(16'h0005);
        send_sample(16'h8000);
        write_window(7'd64);
        send_sample(16'h7fff);
        send_sample(16'h0001);
        s_valid <= 1'b0;
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] fixed_len [8] = '{7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'd127, 7'd0, 7'd8};
        logic [CFG_W-1:0] len;
        t_sample_src      src;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            len = (p < 8) ? fixed_len[p] : CFG_W'($urandom_range(0, 127));
            src = (p % 5 == 3) ? SRC_LOW : (p % 5 == 4) ? SRC_HIGH : SRC_MIXED;
            write_window(len);
            no_idle = (p == 5);
            repeat (PHASE_ITEMS) send_sample(rand_sample(src));
            no_idle = 1'b0;
            s_valid <= 1'b0;
        end
    endtask

    task automatic test_output_stall();
        write_window(CFG_W'($urandom_range(1, MAX_WIN)));
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (STALL_ITEMS) send_sample(rand_sample(SRC_MIXED));
        no_idle  = 1'b0;
        s_valid <= 1'b0;
    endtask

    initial begin
        clear_window(maw_pkg::WINDOW_RESET);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_window();
        test_window_clamp();
        test_random_phases();
        test_output_stall();
        while (expected_avg.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("moving_average_window_core test passed");
        end else begin
            $display("moving_average_window_core test failed");
        end
        $finish;
    end

endmodule
